FILE: rtl/lav_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lav_pkg: shared types and constants of the look-at view matrix block
// Vector types, queue entry layout, register indexes and operand selection.
// ---------------------------------------------------------------------------
package lav_pkg;

    localparam int COMP_W     = 32;
    localparam int UP_W       = 16;
    localparam int DIFF_W     = 33;
    localparam int WIDE_W     = 64;
    localparam int FIFO_DEPTH = 2;

    typedef logic [2:0][COMP_W-1:0] comp3_t;
    typedef logic [2:0][UP_W-1:0]   up3_t;
    typedef logic [2:0][DIFF_W-1:0] diff3_t;
    typedef logic [2:0][WIDE_W-1:0] wide3_t;

    // One queued item: eye position, eye minus target, and the zero flag.
    typedef struct packed {
        comp3_t eye;
        diff3_t diff;
        logic   zero;
    } lav_entry_t;

    // Status of the normalizer as seen by the sequencer.
    typedef struct packed {
        logic done;
        logic ok;
    } norm_status_t;

    localparam logic [1:0] REG_UP_X = 2'd0;
    localparam logic [1:0] REG_UP_Y = 2'd1;
    localparam logic [1:0] REG_UP_Z = 2'd2;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    // Left operand component for product j of a cross product.
    function automatic logic [1:0] cross_sel_a(input logic [2:0] j);
        logic [1:0] r;
        case (j)
            3'd0:    r = 2'd1;
            3'd1:    r = 2'd2;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd0;
            3'd4:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // Right operand component for product j of a cross product.
    function automatic logic [1:0] cross_sel_b(input logic [2:0] j);
        logic [1:0] r;
        case (j)
            3'd0:    r = 2'd2;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd0;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Select one component of a vector.
    function automatic logic [COMP_W-1:0] pick3(input comp3_t v, input logic [1:0] i);
        logic [COMP_W-1:0] r;
        case (i)
            2'd0:    r = v[0];
            2'd1:    r = v[1];
            default: r = v[2];
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/lav_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lav_fifo: short item queue
// Holds classified items between the front and the back of the block.
// ---------------------------------------------------------------------------
module lav_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lav_pkg::lav_entry_t push_data,
    input  logic               pop,
    output lav_pkg::lav_entry_t pop_data,
    output logic               full,
    output logic               empty
);
    import lav_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    lav_entry_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;

    assign full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/lav_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lav_front: item intake
// Accepts eye and target, forms their difference and flags a zero forward.
// ---------------------------------------------------------------------------
module lav_front (
    input  logic                start,
    input  logic                full,
    input  lav_pkg::comp3_t     eye,
    input  lav_pkg::comp3_t     target,
    output logic                push,
    output lav_pkg::lav_entry_t entry
);
    import lav_pkg::*;

    diff3_t diff;

    // Eye minus target, one bit wider than the operands.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = DIFF_W'($signed({eye[i][COMP_W-1], eye[i]})
                      - $signed({target[i][COMP_W-1], target[i]}));
        end
    end

    assign push        = start && !full;
    assign entry.eye   = eye;
    assign entry.diff  = diff;
    assign entry.zero  = (eye == target);

endmodule

FILE: rtl/lav_norm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lav_norm: vector normalizer
// Scales a vector, takes the root of its squared length bit by bit and
// divides each component by the length one quotient bit a cycle.
// ---------------------------------------------------------------------------
module lav_norm #(
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lav_pkg::wide3_t       vec,
    output lav_pkg::norm_status_t status,
    output lav_pkg::comp3_t       unit
);
    import lav_pkg::*;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_ROOT  = 3'd3;
    localparam logic [2:0] N_DIVI  = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;
    localparam logic [2:0] N_DONE  = 3'd6;

    localparam logic [WIDE_W-1:0] MAG_LIMIT = WIDE_W'(1) << 30;

    logic [2:0]             state_reg;
    logic [5:0]             cnt_reg;
    logic [1:0]             idx_reg;
    logic                   ok_reg;
    wide3_t                 mag_reg;
    logic [2:0]             neg_reg;
    logic [WIDE_W-1:0]      max_reg;
    logic [59:0]            prod_reg;
    logic [WIDE_W-1:0]      sum_reg;
    logic [WIDE_W-1:0]      x_reg;
    logic [WIDE_W-1:0]      res_reg;
    logic [WIDE_W-1:0]      bit_reg;
    logic [COMP_W-1:0]      len_reg;
    logic [WIDE_W-1:0]      num_reg;
    logic [COMP_W-1:0]      rem_reg;
    logic [COMP_W-1:0]      quo_reg;
    comp3_t                 unit_reg;

    wide3_t                 mag_in;
    logic [WIDE_W-1:0]      max_in;
    logic [WIDE_W-1:0]      root_trial;
    logic                   root_take;
    logic [WIDE_W-1:0]      res_next;
    logic [COMP_W:0]        div_trial;
    logic                   div_take;
    logic [COMP_W-1:0]      quo_next;

    // Magnitudes and their maximum at intake.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i] = vec[i][WIDE_W-1] ? WIDE_W'(-$signed(vec[i])) : vec[i];
        end
        max_in = mag_in[0];
        if (mag_in[1] > max_in)
        begin
            max_in = mag_in[1];
        end
        if (mag_in[2] > max_in)
        begin
            max_in = mag_in[2];
        end
    end

    // One step of the square root and of the divider.
    always_comb
    begin
        root_trial = res_reg + bit_reg;
        root_take  = (x_reg >= root_trial);
        res_next   = root_take ? (res_reg >> 1) + bit_reg : res_reg >> 1;
        div_trial  = {rem_reg, num_reg[WIDE_W-1]};
        div_take   = (div_trial >= {1'b0, len_reg});
        quo_next   = {quo_reg[COMP_W-2:0], div_take};
    end

    assign status.done = (state_reg == N_DONE);
    assign status.ok   = ok_reg;
    assign unit        = unit_reg;

    // Sequencer of the normalizer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        ok_reg    <= (max_in != '0);
                        state_reg <= (max_in == '0) ? N_DONE : N_SHIFT;
                    end
                end
                N_SHIFT:
                begin
                    if (max_reg < MAG_LIMIT)
                    begin
                        state_reg <= N_SQ;
                        cnt_reg   <= '0;
                    end
                end
                N_SQ:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd3)
                    begin
                        state_reg <= N_ROOT;
                        cnt_reg   <= '0;
                    end
                end
                N_ROOT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd31)
                    begin
                        state_reg <= N_DIVI;
                        idx_reg   <= '0;
                    end
                end
                N_DIVI:
                begin
                    state_reg <= N_DIV;
                    cnt_reg   <= '0;
                end
                N_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd63)
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            state_reg <= N_DONE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= N_DIVI;
                        end
                    end
                end
                N_DONE:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    // Datapath of the normalizer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    mag_reg <= mag_in;
                    max_reg <= max_in;
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vec[i][WIDE_W-1];
                    end
                end
            end
            N_SHIFT:
            begin
                if (max_reg >= MAG_LIMIT)
                begin
                    max_reg <= max_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
            end
            N_SQ:
            begin
                if (cnt_reg != 6'd3)
                begin
                    prod_reg <= mag_reg[cnt_reg[1:0]][29:0] * mag_reg[cnt_reg[1:0]][29:0];
                end
                if (cnt_reg == 6'd0)
                begin
                    sum_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_reg + WIDE_W'(prod_reg);
                end
                if (cnt_reg == 6'd3)
                begin
                    x_reg   <= sum_reg + WIDE_W'(prod_reg);
                    res_reg <= '0;
                    bit_reg <= WIDE_W'(1) << 62;
                end
            end
            N_ROOT:
            begin
                if (root_take)
                begin
                    x_reg <= x_reg - root_trial;
                end
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == 6'd31)
                begin
                    len_reg <= res_next[COMP_W-1:0];
                end
            end
            N_DIVI:
            begin
                num_reg <= (mag_reg[idx_reg] << UNIT_FRAC_BITS)
                           + WIDE_W'(len_reg >> 1);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            N_DIV:
            begin
                rem_reg <= div_take ? COMP_W'(div_trial - {1'b0, len_reg})
                                    : div_trial[COMP_W-1:0];
                num_reg <= num_reg << 1;
                quo_reg <= quo_next;
                if (cnt_reg == 6'd63)
                begin
                    unit_reg[idx_reg] <= neg_reg[idx_reg] ? COMP_W'(-$signed(quo_next))
                                                          : quo_next;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/lav_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lav_back: matrix sequencer
// Runs the cross products and dot products on one shared multiplier, drives
// the normalizer and emits the three matrix rows.
// ---------------------------------------------------------------------------
module lav_back #(
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  lav_pkg::lav_entry_t entry,
    input  lav_pkg::up3_t       up,
    output logic                pop,
    output logic                valid,
    output logic [1:0]          row_index,
    output logic signed [15:0]  elem_x,
    output logic signed [15:0]  elem_y,
    output logic signed [15:0]  elem_z,
    output logic signed [31:0]  row_translation,
    output logic                degenerate,
    output logic                last_row
);
    import lav_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_FWD  = 3'd1;
    localparam logic [2:0] B_CR1  = 3'd2;
    localparam logic [2:0] B_RGT  = 3'd3;
    localparam logic [2:0] B_CR2  = 3'd4;
    localparam logic [2:0] B_TUP  = 3'd5;
    localparam logic [2:0] B_DOT  = 3'd6;
    localparam logic [2:0] B_FAIL = 3'd7;

    localparam logic [WIDE_W-1:0] HALF    = WIDE_W'(1) << (UNIT_FRAC_BITS - 1);
    localparam logic [WIDE_W-1:0] NEG_LIM = WIDE_W'(64'd2147483648);
    localparam logic [WIDE_W-1:0] POS_LIM = WIDE_W'(64'd2147483647);

    logic [2:0]               state_reg;
    logic [2:0]               cnt_reg;
    logic [1:0]               row_reg;
    logic                     start_reg;
    comp3_t                   eye_reg;
    comp3_t                   fwd_reg;
    comp3_t                   rgt_reg;
    comp3_t                   tup_reg;
    wide3_t                   acc_reg;
    logic signed [WIDE_W-1:0] mul_reg;
    logic signed [WIDE_W-1:0] dot_reg;
    logic                     valid_reg;
    logic [1:0]               row_index_reg;
    logic [15:0]              elem_x_reg;
    logic [15:0]              elem_y_reg;
    logic [15:0]              elem_z_reg;
    logic [31:0]              trans_reg;
    logic                     degen_reg;
    logic                     last_reg;

    norm_status_t             norm_status;
    comp3_t                   norm_unit;
    comp3_t                   up_wide;
    comp3_t                   row_vec;
    logic [COMP_W-1:0]        op_a;
    logic [COMP_W-1:0]        op_b;
    logic [2:0]               prod_j;
    logic [1:0]               acc_idx;
    logic signed [WIDE_W-1:0] dot_fin;
    logic [WIDE_W-1:0]        dot_mag;
    logic [WIDE_W-1:0]        dot_rnd;
    logic [31:0]              trans_val;

    lav_norm #(
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .vec    (acc_reg),
        .status (norm_status),
        .unit   (norm_unit)
    );

    // Operand selection for the shared multiplier.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            up_wide[i] = COMP_W'($signed(up[i]));
        end
        case (row_reg)
            ROW_RIGHT: row_vec = rgt_reg;
            ROW_UP:    row_vec = tup_reg;
            default:   row_vec = fwd_reg;
        endcase
        prod_j  = cnt_reg - 3'd1;
        acc_idx = prod_j[2:1];
        case (state_reg)
            B_CR1:
            begin
                op_a = pick3(up_wide, cross_sel_a(cnt_reg));
                op_b = pick3(fwd_reg, cross_sel_b(cnt_reg));
            end
            B_CR2:
            begin
                op_a = pick3(fwd_reg, cross_sel_a(cnt_reg));
                op_b = pick3(rgt_reg, cross_sel_b(cnt_reg));
            end
            default:
            begin
                op_a = pick3(row_vec, cnt_reg[1:0]);
                op_b = pick3(eye_reg, cnt_reg[1:0]);
            end
        endcase
    end

    // Negated dot product, rounded half away from zero and saturated.
    always_comb
    begin
        dot_fin = dot_reg + mul_reg;
        dot_mag = dot_fin[WIDE_W-1] ? WIDE_W'(-dot_fin) : WIDE_W'(dot_fin);
        dot_rnd = (dot_mag + HALF) >> UNIT_FRAC_BITS;
        if (dot_fin > 0)
        begin
            trans_val = (dot_rnd > NEG_LIM) ? 32'h8000_0000 : 32'(-dot_rnd);
        end
        else
        begin
            trans_val = (dot_rnd > POS_LIM) ? 32'h7FFF_FFFF : dot_rnd[31:0];
        end
    end

    assign pop             = (state_reg == B_IDLE) && !empty;
    assign valid           = valid_reg;
    assign row_index       = row_index_reg;
    assign elem_x          = elem_x_reg;
    assign elem_y          = elem_y_reg;
    assign elem_z          = elem_z_reg;
    assign row_translation = trans_reg;
    assign degenerate      = degen_reg;
    assign last_row        = last_reg;

    // Sequencer control and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            row_reg   <= '0;
            start_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        row_reg <= ROW_RIGHT;
                        if (entry.zero)
                        begin
                            state_reg <= B_FAIL;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            state_reg <= B_FWD;
                        end
                    end
                end
                B_FWD, B_RGT, B_TUP:
                begin
                    if (norm_status.done)
                    begin
                        cnt_reg <= '0;
                        row_reg <= ROW_RIGHT;
                        if (!norm_status.ok)
                        begin
                            state_reg <= B_FAIL;
                        end
                        else if (state_reg == B_FWD)
                        begin
                            state_reg <= B_CR1;
                        end
                        else if (state_reg == B_RGT)
                        begin
                            state_reg <= B_CR2;
                        end
                        else
                        begin
                            state_reg <= B_DOT;
                        end
                    end
                end
                B_CR1, B_CR2:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd6)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= (state_reg == B_CR1) ? B_RGT : B_TUP;
                    end
                end
                B_DOT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd3)
                    begin
                        valid_reg <= 1'b1;
                        cnt_reg   <= '0;
                        row_reg   <= row_reg + 1'b1;
                        if (row_reg == ROW_FWD)
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                B_FAIL:
                begin
                    valid_reg <= 1'b1;
                    row_reg   <= row_reg + 1'b1;
                    if (row_reg == ROW_FWD)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Vector registers, multiplier and result payload.
    always_ff @(posedge clk)
    begin
        mul_reg <= $signed(op_a) * $signed(op_b);
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    eye_reg <= entry.eye;
                    for (int i = 0; i < 3; i++)
                    begin
                        acc_reg[i] <= WIDE_W'($signed(entry.diff[i]));
                    end
                end
            end
            B_FWD:
            begin
                if (norm_status.done)
                begin
                    fwd_reg <= norm_unit;
                end
            end
            B_RGT:
            begin
                if (norm_status.done)
                begin
                    rgt_reg <= norm_unit;
                end
            end
            B_TUP:
            begin
                if (norm_status.done)
                begin
                    tup_reg <= norm_unit;
                end
            end
            B_CR1, B_CR2:
            begin
                if (cnt_reg != 3'd0)
                begin
                    acc_reg[acc_idx] <= prod_j[0] ? WIDE_W'($signed(acc_reg[acc_idx]) - mul_reg)
                                                  : WIDE_W'(mul_reg);
                end
            end
            B_DOT:
            begin
                if (cnt_reg == 3'd1)
                begin
                    dot_reg <= mul_reg;
                end
                else if (cnt_reg == 3'd2)
                begin
                    dot_reg <= dot_reg + mul_reg;
                end
                else if (cnt_reg == 3'd3)
                begin
                    row_index_reg <= row_reg;
                    elem_x_reg    <= row_vec[0][15:0];
                    elem_y_reg    <= row_vec[1][15:0];
                    elem_z_reg    <= row_vec[2][15:0];
                    trans_reg     <= trans_val;
                    degen_reg     <= 1'b0;
                    last_reg      <= (row_reg == ROW_FWD);
                end
            end
            B_FAIL:
            begin
                row_index_reg <= row_reg;
                elem_x_reg    <= '0;
                elem_y_reg    <= '0;
                elem_z_reg    <= '0;
                trans_reg     <= '0;
                degen_reg     <= 1'b1;
                last_reg      <= (row_reg == ROW_FWD);
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// look_at_view_matrix: fixed-point look-at view matrix
// Forms right, true up and forward rows with translations from eye and target.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry queue lets
// up to two items wait while one is in work. Each item yields three rows on
// valid, one cycle each, which the receiver must take as they come. An item
// passes three times through the shared normalizer, each pass a scaling
// shift when needed, a bit-serial square root of 32 steps and three 64-step
// dividers, followed by two cross products and three dot products on one
// multiplier. An item with eye equal to target gives its three degenerate
// rows without these passes.
module look_at_view_matrix #(
    parameter int UNIT_FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    output logic               valid,
    output logic [1:0]         row_index,
    output logic signed [15:0] elem_x,
    output logic signed [15:0] elem_y,
    output logic signed [15:0] elem_z,
    output logic signed [31:0] row_translation,
    output logic               degenerate,
    output logic               last_row
);
    import lav_pkg::*;

    up3_t       up_reg;
    comp3_t     eye;
    comp3_t     target;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    lav_entry_t push_data;
    lav_entry_t pop_data;
    logic       cfg_write;

    assign eye    = {eye_z, eye_y, eye_x};
    assign target = {target_z, target_y, target_x};
    assign busy   = full;
    assign pready = 1'b1;

    // Configuration register writes.
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg[0] <= 16'sd0;
            up_reg[1] <= 16'sd16384;
            up_reg[2] <= 16'sd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_UP_X: up_reg[0] <= pwdata[15:0];
                REG_UP_Y: up_reg[1] <= pwdata[15:0];
                REG_UP_Z: up_reg[2] <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        case (paddr[3:2])
            REG_UP_X: prdata = 32'($signed(up_reg[0]));
            REG_UP_Y: prdata = 32'($signed(up_reg[1]));
            REG_UP_Z: prdata = 32'($signed(up_reg[2]));
            default:  prdata = '0;
        endcase
    end

    lav_front u_front (
        .start  (start),
        .full   (full),
        .eye    (eye),
        .target (target),
        .push   (push),
        .entry  (push_data)
    );

    lav_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    lav_back #(
        .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .empty           (empty),
        .entry           (pop_data),
        .up              (up_reg),
        .pop             (pop),
        .valid           (valid),
        .row_index       (row_index),
        .elem_x          (elem_x),
        .elem_y          (elem_y),
        .elem_z          (elem_z),
        .row_translation (row_translation),
        .degenerate      (degenerate),
        .last_row        (last_row)
    );

endmodule

FILE: rtl/lav_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lav_checker: port-level assertions
// Checks row tagging, degenerate rows and register read-back over time.
// ---------------------------------------------------------------------------
module lav_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [3:0]         paddr,
    input logic [31:0]        pwdata,
    input logic [31:0]        prdata,
    input logic               valid,
    input logic [1:0]         row_index,
    input logic signed [15:0] elem_x,
    input logic signed [15:0] elem_y,
    input logic signed [15:0] elem_z,
    input logic signed [31:0] row_translation,
    input logic               degenerate,
    input logic               last_row
);

    // The last-row flag marks the forward row and no other.
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (last_row == (row_index == 2'd2)))
        else $error("last_row does not match row_index");

    // A degenerate row carries zeros only.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && degenerate |-> (elem_x == 16'sd0) && (elem_y == 16'sd0)
                                && (elem_z == 16'sd0) && (row_translation == 32'sd0))
        else $error("degenerate row with nonzero payload");

    // Degenerate rows of one item come back to back.
    a_degen_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid && degenerate && (row_index != 2'd0) |-> $past(valid) && $past(degenerate))
        else $error("degenerate rows not back to back");

    // A written up_x reads back on the next cycle.
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[3:2] == 2'd0)
        |=> (paddr[3:2] != 2'd0) || (prdata[15:0] == $past(pwdata[15:0])))
        else $error("up_x read-back mismatch");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .valid           (valid),
    .row_index       (row_index),
    .elem_x          (elem_x),
    .elem_y          (elem_y),
    .elem_z          (elem_z),
    .row_translation (row_translation),
    .degenerate      (degenerate),
    .last_row        (last_row)
);

FILE: sim/look_at_view_matrix_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// look_at_view_matrix_tb: self-checking testbench of the look-at view matrix
// Sends eye and target points through the start/busy handshake with random
// gaps and programs the world up vector over the APB port between phases. A
// fixed-point predictor builds the three expected rows of each item, and a
// checker compares every row on valid against the oldest expected row.
// ---------------------------------------------------------------------------
module look_at_view_matrix_tb;
    import lav_pkg::*;

    localparam int UNIT_FRAC_BITS = 14;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [1:0]  row_index;
        logic [15:0] elem_x;
        logic [15:0] elem_y;
        logic [15:0] elem_z;
        logic [31:0] row_translation;
        logic        degenerate;
        logic        last_row;
    } view_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic        valid;
    logic [1:0]  row_index;
    logic signed [15:0] elem_x;
    logic signed [15:0] elem_y;
    logic signed [15:0] elem_z;
    logic signed [31:0] row_translation;
    logic        degenerate;
    logic        last_row;

    view_row_t   pending_rows[$];
    longint      up_vec[3];
    int          error_count;
    longint      cycle_count;

    look_at_view_matrix #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .valid(valid), .row_index(row_index),
        .elem_x(elem_x), .elem_y(elem_y), .elem_z(elem_z),
        .row_translation(row_translation), .degenerate(degenerate),
        .last_row(last_row)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Floor integer square root, bit by bit.
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Scale a vector to unit length in Q2.14; returns 0 on a zero length.
    function automatic bit unit_vector(input longint v[3], output longint u[3]);
        longint unsigned mag[3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        int s;
        m = 0;
        sum = 0;
        s = 0;
        u = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
            return 0;
        while ((m >> s) >= (64'd1 << 30))
            s++;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> s;
            sum = sum + mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        if (len == 0)
            return 0;
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << UNIT_FRAC_BITS) + len / 2) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic void cross_product(input longint a[3], input longint b[3],
                                          output longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Minus row dot eye, rounded half away from zero and saturated to Q16.16.
    function automatic logic [31:0] row_offset(input longint r[3], input longint e[3]);
        longint dot;
        longint unsigned mag;
        dot = r[0] * e[0] + r[1] * e[1] + r[2] * e[2];
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        mag = (mag + (64'd1 << (UNIT_FRAC_BITS - 1))) >> UNIT_FRAC_BITS;
        if (dot > 0)
            return (mag > 64'd2147483648) ? 32'h8000_0000 : 32'(-longint'(mag));
        return (mag > 64'd2147483647) ? 32'h7FFF_FFFF : 32'(mag);
    endfunction

    // Build the three expected rows of one item from the current up vector.
    task automatic predict_view_rows(input logic signed [31:0] e[3],
                                     input logic signed [31:0] t[3]);
        longint eye_v[3];
        longint diff[3];
        longint fwd[3];
        longint right_v[3];
        longint true_up[3];
        longint tmp[3];
        longint rows[3][3];
        bit ok;
        view_row_t r;
        for (int i = 0; i < 3; i++)
        begin
            eye_v[i] = e[i];
            diff[i] = longint'(e[i]) - longint'(t[i]);
        end
        ok = unit_vector(diff, fwd);
        if (ok)
        begin
            cross_product(up_vec, fwd, tmp);
            ok = unit_vector(tmp, right_v);
        end
        if (ok)
        begin
            cross_product(fwd, right_v, tmp);
            ok = unit_vector(tmp, true_up);
        end
        rows[ROW_RIGHT] = right_v;
        rows[ROW_UP] = true_up;
        rows[ROW_FWD] = fwd;
        for (int k = 0; k < 3; k++)
        begin
            r.row_index = 2'(k);
            r.last_row = (2'(k) == ROW_FWD);
            r.degenerate = !ok;
            r.elem_x = ok ? 16'(rows[k][0]) : 16'd0;
            r.elem_y = ok ? 16'(rows[k][1]) : 16'd0;
            r.elem_z = ok ? 16'(rows[k][2]) : 16'd0;
            r.row_translation = ok ? row_offset(rows[k], eye_v) : 32'd0;
            pending_rows.push_back(r);
        end
    endtask

    // Compare each row transfer with the oldest expected row.
    always @(posedge clk)
    begin
        view_row_t x;
        if (rst_n && valid)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: unexpected row %0d", $time, row_index);
                error_count++;
            end
            else
            begin
                x = pending_rows.pop_front();
                if (row_index !== x.row_index || elem_x !== x.elem_x ||
                    elem_y !== x.elem_y || elem_z !== x.elem_z ||
                    row_translation !== x.row_translation ||
                    degenerate !== x.degenerate || last_row !== x.last_row)
                begin
                    $display("%0t: row mismatch expected %0d %h %h %h %h %b %b",
                             $time, x.row_index, x.elem_x, x.elem_y, x.elem_z,
                             x.row_translation, x.degenerate, x.last_row);
                    $display("%0t:              actual   %0d %h %h %h %h %b %b",
                             $time, row_index, elem_x, elem_y, elem_z,
                             row_translation, degenerate, last_row);
                    error_count++;
                end
            end
        end
    end

    // Gap length: mostly none, sometimes short, rarely long.
    function automatic int gap_cycles();
        int p;
        p = $urandom_range(99);
        if (p < 60)
            return 0;
        if (p < 95)
            return $urandom_range(5, 1);
        return $urandom_range(300, 20);
    endfunction

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic send_view(input logic signed [31:0] e[3],
                             input logic signed [31:0] t[3]);
        logic taken;
        @(negedge clk);
        eye_x = e[0];
        eye_y = e[1];
        eye_z = e[2];
        target_x = t[0];
        target_y = t[1];
        target_z = t[2];
        start = 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        predict_view_rows(e, t);
        idle_cycles(gap_cycles());
    endtask

    // Wait until every expected row has arrived and the block is quiet.
    task automatic drain_rows();
        idle_cycles(1);
        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // APB write of one up-vector component.
    task automatic write_up(input logic [1:0] idx, input logic [15:0] value);
        drain_rows();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = {{16{value[15]}}, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        up_vec[idx] = longint'($signed(value));
    endtask

    task automatic set_up(input logic [15:0] ux, input logic [15:0] uy,
                          input logic [15:0] uz);
        write_up(REG_UP_X, ux);
        write_up(REG_UP_Y, uy);
        write_up(REG_UP_Z, uz);
    endtask

    task automatic send_xyz(input logic [31:0] ex, input logic [31:0] ey,
                            input logic [31:0] ez, input logic [31:0] tx,
                            input logic [31:0] ty, input logic [31:0] tz);
        logic signed [31:0] e[3];
        logic signed [31:0] t[3];
        e = '{ex, ey, ez};
        t = '{tx, ty, tz};
        send_view(e, t);
    endtask

    // Field extremes and typical views with the reset up vector.
    task automatic test_directed_views();
        send_xyz(32'h0005_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
        send_xyz(0, 0, 32'h0001_0000, 0, 0, 0);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 2);
        send_xyz(1, 0, 0, 0, 0, 1);
        send_xyz(32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0001, 0, 0, 0);
    endtask

    // Eye on target, forward along or against up, a zero up vector and extreme up vectors.
    task automatic test_degenerate_views();
        send_xyz(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_xyz(0, 32'h0004_0000, 0, 0, 0, 0);
        send_xyz(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0);
        set_up(16'd0, 16'd0, 16'd0);
        send_xyz(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0);
        set_up(16'h8000, 16'h7FFF, 16'hC000);
        send_xyz(32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        set_up(16'd16384, 16'd0, 16'd0);
        send_xyz(32'h0002_0000, 0, 0, 0, 0, 0);
        send_xyz(0, 32'h0002_0000, 32'h0001_0000, 0, 0, 0);
        set_up(16'hC000, 16'hC000, 16'hC000);
        send_xyz(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
        send_xyz(32'h0002_0000, 32'h0001_0000, 0, 0, 0, 0);
    endtask

    // One random item: mostly ordinary views, some on target or along up.
    task automatic send_random_view();
        logic signed [31:0] e[3];
        logic signed [31:0] t[3];
        int mode;
        int sh;
        int k;
        mode = $urandom_range(99);
        sh = $urandom_range(30);
        k = $urandom_range(64, 1);
        for (int i = 0; i < 3; i++)
        begin
            e[i] = $urandom;
            if (mode < 25)
                t[i] = $urandom;
            else if (mode < 75)
            begin
                e[i] = $signed(e[i]) >>> 1;
                t[i] = e[i] - ($signed(32'($urandom)) >>> sh);
            end
            else if (mode < 85)
                t[i] = e[i];
            else
            begin
                e[i] = $signed(e[i]) >>> 2;
                t[i] = e[i] - 32'(up_vec[i] * k);
            end
        end
        send_view(e, t);
    endtask

    // Several up-vector settings, each with a run of random items.
    task automatic test_random_views(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            case (p % 4)
                0: set_up(16'd0, 16'd16384, 16'd0);
                1: set_up(16'($urandom_range(32768) - 16384),
                          16'($urandom_range(32768) - 16384),
                          16'($urandom_range(32768) - 16384));
                2: set_up(16'($urandom), 16'($urandom), 16'($urandom));
                default: set_up(16'hC000, 16'd16384, 16'd0);
            endcase
            for (int i = 0; i < per_phase; i++)
                send_random_view();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        eye_x = '0;
        eye_y = '0;
        eye_z = '0;
        target_x = '0;
        target_y = '0;
        target_z = '0;
        error_count = 0;
        cycle_count = 0;
        up_vec = '{0, 16384, 0};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_views();
        test_degenerate_views();
        test_random_views(8, 56);

        drain_rows();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
